FILE: design/assert_macros.svh
// assertion macros shared by the gradient core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the core clock, off during reset
`define W5G_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the core clock, off during reset
`define W5G_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/w5g_pkg.sv
// types and constants of the weno5 upwind gradient core
package w5g_pkg;

  // sample format
  localparam int SAMPLE_WIDTH = 32;
  localparam int FRAC_BITS    = 16;
  localparam int DIFF_W       = SAMPLE_WIDTH + 1;

  // internal fixed point formats
  localparam int INV_FRAC  = 16;
  localparam int INT_FRAC  = FRAC_BITS + INV_FRAC;
  localparam int W_FRAC    = 29;
  localparam int OUT_SHIFT = W_FRAC + INV_FRAC;
  localparam int PMAG_W    = 62;

  localparam logic [63:0] Q_LIM   = (64'd1 << 58) - 64'd1;
  localparam logic [63:0] EPS_RAW = ((64'd1 << INT_FRAC) + 64'd500000) / 64'd1000000;
  localparam logic [63:0] EPS12   = 64'd12 * EPS_RAW;

  // result limits
  localparam logic [31:0] GRAD_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] GRAD_MIN = 32'h8000_0000;

  // configuration space
  localparam int          PADDR_W         = 3;
  localparam int unsigned REG_INV_SPACING = 0;
  localparam logic [31:0] INV_RESET       = 32'd65536;

  // upwind mode codes
  typedef enum logic [1:0] {
    MODE_ZERO = 2'd0,
    MODE_POS  = 2'd1,
    MODE_NEG  = 2'd2
  } mode_e;

  // one input item
  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_m3;
    logic signed [SAMPLE_WIDTH-1:0] sample_m2;
    logic signed [SAMPLE_WIDTH-1:0] sample_m1;
    logic signed [SAMPLE_WIDTH-1:0] sample_center;
    logic signed [SAMPLE_WIDTH-1:0] sample_p1;
    logic signed [SAMPLE_WIDTH-1:0] sample_p2;
    logic signed [SAMPLE_WIDTH-1:0] sample_p3;
    logic [1:0]                     mode;
  } w5g_in_t;

  // one result item
  typedef struct packed {
    logic signed [31:0] gradient;
    logic               saturated;
  } w5g_out_t;

endpackage

FILE: design/weno5_upwind_gradient_core.sv
// weno5 upwind gradient core: fully pipelined fifth-order weno derivative
//
// One item is taken in every clock cycle (busy stays low) and its result
// appears on result_o, marked by strobe_o for one cycle. The latency is set
// by the two bit-serial pipelined dividers: 32 stages for the smoothness
// ratios and 30 stages for the weight normalization, plus 15 stages of
// differencing, squaring and the final weighted sum. Results cannot be held
// off, so the pipeline never stalls. inv_spacing may only be written while
// no item is in flight.
`include "assert_macros.svh"

module weno5_upwind_gradient_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  w5g_pkg::w5g_in_t          item_i,
  output logic                      strobe_o,
  output w5g_pkg::w5g_out_t         result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [w5g_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import w5g_pkg::*;

  localparam int DIV1_STEPS  = 32;
  localparam int DIV2_STEPS  = W_FRAC + 1;
  localparam int ST_DIV1     = 10;
  localparam int ST_R        = ST_DIV1 + DIV1_STEPS;
  localparam int ST_A        = ST_R + 2;
  localparam int ST_W        = ST_A + DIV2_STEPS;
  localparam int LAT         = ST_W + 3;
  localparam int ST_P        = 4 + 2;
  localparam int P_DELAY     = ST_W - ST_P;

  // reciprocal of six scaled by 2^66, rounded up, in two halves
  localparam logic [31:0] RCP6_HI = 32'hAAAA_AAAA;
  localparam logic [31:0] RCP6_LO = 32'hAAAA_AAAB;
  localparam logic [31:0] RATIO_ONE = 32'h8000_0000;

  localparam logic signed [95:0] Y_MAX = 96'sd2147483647;
  localparam logic signed [95:0] Y_MIN = -96'sd2147483648;
  localparam logic signed [95:0] RND   = 96'sd1 <<< (OUT_SHIFT - 1);

  // absolute value of a signed 64-bit word
  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? 64'(n) : 64'(v);
  endfunction

  // number of significant bits
  function automatic logic [6:0] bitlen64(input logic [63:0] v);
    logic [6:0] n;
    n = '0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // configuration register
  logic [31:0] inv_q;
  logic        cfg_wr;
  logic        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PADDR_W-1:2] == 1'(REG_INV_SPACING));
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = cfg_sel ? inv_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= INV_RESET;
    end else if (cfg_wr && cfg_sel) begin
      inv_q <= pwdata;
    end
  end

  // item valid and active-mode flags travel down the pipe
  logic           accept;
  logic           act_in;
  logic [LAT:1]   vld_q;
  logic [LAT-1:1] act_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign act_in = (item_i.mode == MODE_POS) || (item_i.mode == MODE_NEG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-1:1], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= {act_q[LAT-2:1], act_in};
  end

  // stage 1: mirrored stencil differences, split into sign and magnitude
  logic signed [SAMPLE_WIDTH-1:0] smp [7];
  logic [DIFF_W-1:0]              mag_d [5];
  logic                           neg_d [5];
  logic [DIFF_W-1:0]              mag1_q [5];
  logic                           neg1_q [5];

  assign smp[0] = item_i.sample_m3;
  assign smp[1] = item_i.sample_m2;
  assign smp[2] = item_i.sample_m1;
  assign smp[3] = item_i.sample_center;
  assign smp[4] = item_i.sample_p1;
  assign smp[5] = item_i.sample_p2;
  assign smp[6] = item_i.sample_p3;

  always_comb begin
    logic signed [SAMPLE_WIDTH-1:0] hi;
    logic signed [SAMPLE_WIDTH-1:0] lo;
    logic signed [DIFF_W-1:0]       dif;
    logic signed [DIFF_W-1:0]       ndif;
    for (int k = 0; k < 5; k++) begin
      if (item_i.mode == MODE_NEG) begin
        hi = smp[6-k];
        lo = smp[5-k];
      end else begin
        hi = smp[k+1];
        lo = smp[k];
      end
      dif      = $signed({hi[SAMPLE_WIDTH-1], hi}) - $signed({lo[SAMPLE_WIDTH-1], lo});
      ndif     = -dif;
      neg_d[k] = dif[DIFF_W-1];
      mag_d[k] = dif[DIFF_W-1] ? DIFF_W'(ndif) : DIFF_W'(dif);
    end
  end

  // stages 1 to 3: scale by the reciprocal spacing and clip
  logic [63:0]        plo2_q [5];
  logic [63:0]        phi2_q [5];
  logic               neg2_q [5];
  logic signed [63:0] q3_q   [5];

  always_ff @(posedge clk_i) begin
    logic [63:0] ext;
    logic [95:0] prod;
    logic [63:0] qmag;
    for (int k = 0; k < 5; k++) begin
      mag1_q[k] <= mag_d[k];
      neg1_q[k] <= neg_d[k];

      ext       = 64'(mag1_q[k]);
      plo2_q[k] <= 64'(ext[31:0]) * 64'(inv_q);
      phi2_q[k] <= 64'(ext[63:32]) * 64'(inv_q);
      neg2_q[k] <= neg1_q[k];

      prod      = {32'd0, plo2_q[k]} + {phi2_q[k], 32'd0};
      qmag      = (prod > {32'd0, Q_LIM}) ? Q_LIM : prod[63:0];
      q3_q[k]   <= neg2_q[k] ? -$signed(qmag) : $signed(qmag);
    end
  end

  // stage 4: smoothness terms and candidate numerators
  logic [63:0] sqin4_q [6];
  logic [63:0] pnum4_q [3];
  logic        pneg4_q [3];

  always_ff @(posedge clk_i) begin
    logic signed [63:0] n [3];
    n[0] = 2 * q3_q[0] - 7 * q3_q[1] + 11 * q3_q[2];
    n[1] = -q3_q[1] + 5 * q3_q[2] + 2 * q3_q[3];
    n[2] = 2 * q3_q[2] + 5 * q3_q[3] - q3_q[4];
    sqin4_q[0] <= abs64(q3_q[0] - 2 * q3_q[1] + q3_q[2]);
    sqin4_q[1] <= abs64(q3_q[1] - 2 * q3_q[2] + q3_q[3]);
    sqin4_q[2] <= abs64(q3_q[2] - 2 * q3_q[3] + q3_q[4]);
    sqin4_q[3] <= abs64(q3_q[0] - 4 * q3_q[1] + 3 * q3_q[2]);
    sqin4_q[4] <= abs64(q3_q[1] - q3_q[3]);
    sqin4_q[5] <= abs64(3 * q3_q[2] - 4 * q3_q[3] + q3_q[4]);
    for (int k = 0; k < 3; k++) begin
      pnum4_q[k] <= abs64(n[k]) + 64'd3;
      pneg4_q[k] <= n[k][63];
    end
  end

  // candidate gradients: divide by six with the reciprocal, then wait for the weights
  logic [63:0]       pp5_q    [3][4];
  logic              pneg5_q  [3];
  logic [PMAG_W-1:0] pdl_q    [3][P_DELAY+1];
  logic              pdlneg_q [3][P_DELAY+1];

  always_ff @(posedge clk_i) begin
    logic [127:0] prod;
    for (int k = 0; k < 3; k++) begin
      pp5_q[k][0] <= 64'(pnum4_q[k][31:0]) * 64'(RCP6_LO);
      pp5_q[k][1] <= 64'(pnum4_q[k][31:0]) * 64'(RCP6_HI);
      pp5_q[k][2] <= 64'(pnum4_q[k][63:32]) * 64'(RCP6_LO);
      pp5_q[k][3] <= 64'(pnum4_q[k][63:32]) * 64'(RCP6_HI);
      pneg5_q[k]  <= pneg4_q[k];

      prod = 128'(pp5_q[k][0]) + (128'(pp5_q[k][1]) << 32) +
             (128'(pp5_q[k][2]) << 32) + (128'(pp5_q[k][3]) << 64);
      pdl_q[k][0]    <= prod[127:66];
      pdlneg_q[k][0] <= pneg5_q[k];
      for (int j = 1; j <= P_DELAY; j++) begin
        pdl_q[k][j]    <= pdl_q[k][j-1];
        pdlneg_q[k][j] <= pdlneg_q[k][j-1];
      end
    end
  end

  // stages 5 to 8: squares, indicator sums, epsilon
  logic [63:0]  ll5_q [6];
  logic [63:0]  lh5_q [6];
  logic [63:0]  hh5_q [6];
  logic [127:0] sq6_q [6];
  logic [127:0] g7_q  [3];
  logic [63:0]  d8_q  [3];

  always_ff @(posedge clk_i) begin
    logic [127:0] b;
    logic [127:0] e;
    logic [63:0]  h;
    for (int j = 0; j < 6; j++) begin
      ll5_q[j] <= 64'(sqin4_q[j][31:0]) * 64'(sqin4_q[j][31:0]);
      lh5_q[j] <= 64'(sqin4_q[j][31:0]) * 64'(sqin4_q[j][63:32]);
      hh5_q[j] <= 64'(sqin4_q[j][63:32]) * 64'(sqin4_q[j][63:32]);
      sq6_q[j] <= (128'(hh5_q[j]) << 64) + (128'(lh5_q[j]) << 33) + 128'(ll5_q[j]);
    end
    for (int k = 0; k < 3; k++) begin
      b        = sq6_q[k];
      e        = sq6_q[k+3];
      g7_q[k]  <= (b << 3) + (b << 2) + b + (e << 1) + e;
      h        = (|g7_q[k][127:64+INT_FRAC]) ? '1 : g7_q[k][63+INT_FRAC:INT_FRAC];
      d8_q[k]  <= (h > ('1 - EPS12)) ? '1 : h + EPS12;
    end
  end

  // stage 9: minimum indicator and per-lane normalizing shift
  logic [63:0] m9_q;
  logic [63:0] d9_q  [3];
  logic [5:0]  sh9_q [3];

  always_ff @(posedge clk_i) begin
    logic [63:0] m;
    logic [6:0]  len;
    m = d8_q[0];
    if (d8_q[1] < m) m = d8_q[1];
    if (d8_q[2] < m) m = d8_q[2];
    m9_q <= m;
    for (int k = 0; k < 3; k++) begin
      len      = bitlen64(d8_q[k]);
      d9_q[k]  <= d8_q[k];
      sh9_q[k] <= (len > 7'd32) ? 6'(len - 7'd32) : 6'd0;
    end
  end

  // stage 10 and ratio divider: r = min * 2^31 / d, one bit per stage
  logic [33:0] r1rem_q [3][DIV1_STEPS+1];
  logic [31:0] r1den_q [3][DIV1_STEPS+1];
  logic [31:0] r1quo_q [3][DIV1_STEPS+1];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      r1rem_q[k][0] <= 34'(32'(m9_q >> sh9_q[k]));
      r1den_q[k][0] <= 32'(d9_q[k] >> sh9_q[k]);
      r1quo_q[k][0] <= '0;
      for (int j = 0; j < DIV1_STEPS; j++) begin
        r1den_q[k][j+1] <= r1den_q[k][j];
        if (r1rem_q[k][j] >= {2'b00, r1den_q[k][j]}) begin
          r1rem_q[k][j+1] <= 34'((r1rem_q[k][j] - {2'b00, r1den_q[k][j]}) << 1);
          r1quo_q[k][j+1] <= {r1quo_q[k][j][30:0], 1'b1};
        end else begin
          r1rem_q[k][j+1] <= 34'(r1rem_q[k][j] << 1);
          r1quo_q[k][j+1] <= {r1quo_q[k][j][30:0], 1'b0};
        end
      end
    end
  end

  // ratio squares, weighted alphas and their sum, then the weight divider:
  // w = alpha * 2^29 / sum, one bit per stage
  logic [63:0] rsq_q   [3];
  logic [35:0] r2rem_q [3][DIV2_STEPS+1];
  logic [34:0] r2den_q [DIV2_STEPS+1];
  logic [29:0] r2quo_q [3][DIV2_STEPS+1];

  always_ff @(posedge clk_i) begin
    logic [34:0] s [3];
    logic [34:0] a [3];
    for (int k = 0; k < 3; k++) begin
      rsq_q[k] <= 64'(r1quo_q[k][DIV1_STEPS]) * 64'(r1quo_q[k][DIV1_STEPS]);
      s[k]     = 35'(rsq_q[k][62:31]);
    end
    a[0] = s[0];
    a[1] = (s[1] << 2) + (s[1] << 1);
    a[2] = (s[2] << 1) + s[2];
    r2den_q[0] <= a[0] + a[1] + a[2];
    for (int k = 0; k < 3; k++) begin
      r2rem_q[k][0] <= 36'(a[k]);
      r2quo_q[k][0] <= '0;
    end
    for (int j = 0; j < DIV2_STEPS; j++) begin
      r2den_q[j+1] <= r2den_q[j];
      for (int k = 0; k < 3; k++) begin
        if (r2rem_q[k][j] >= {1'b0, r2den_q[j]}) begin
          r2rem_q[k][j+1] <= 36'((r2rem_q[k][j] - {1'b0, r2den_q[j]}) << 1);
          r2quo_q[k][j+1] <= {r2quo_q[k][j][28:0], 1'b1};
        end else begin
          r2rem_q[k][j+1] <= 36'(r2rem_q[k][j] << 1);
          r2quo_q[k][j+1] <= {r2quo_q[k][j][28:0], 1'b0};
        end
      end
    end
  end

  // weighted sum of candidates, rounding and saturation
  logic [63:0]        f1lo_q  [3];
  logic [63:0]        f1hi_q  [3];
  logic               f1neg_q [3];
  logic signed [95:0] acc_q;
  w5g_out_t           res_q;

  always_ff @(posedge clk_i) begin
    logic [PMAG_W-1:0]  pm;
    logic [95:0]        t;
    logic signed [95:0] sum;
    logic signed [95:0] y;
    for (int k = 0; k < 3; k++) begin
      pm          = pdl_q[k][P_DELAY];
      f1lo_q[k]  <= 64'(r2quo_q[k][DIV2_STEPS]) * 64'(pm[31:0]);
      f1hi_q[k]  <= 64'(r2quo_q[k][DIV2_STEPS]) * 64'(pm[PMAG_W-1:32]);
      f1neg_q[k] <= pdlneg_q[k][P_DELAY];
    end
    sum = RND;
    for (int k = 0; k < 3; k++) begin
      t   = 96'(f1lo_q[k]) + (96'(f1hi_q[k]) << 32);
      sum = f1neg_q[k] ? sum - $signed(t) : sum + $signed(t);
    end
    acc_q <= sum;
    y = acc_q >>> OUT_SHIFT;
    if (!act_q[LAT-1]) begin
      res_q.gradient  <= '0;
      res_q.saturated <= 1'b0;
    end else if (y > Y_MAX) begin
      res_q.gradient  <= GRAD_MAX;
      res_q.saturated <= 1'b1;
    end else if (y < Y_MIN) begin
      res_q.gradient  <= GRAD_MIN;
      res_q.saturated <= 1'b1;
    end else begin
      res_q.gradient  <= y[31:0];
      res_q.saturated <= 1'b0;
    end
  end

  assign strobe_o = vld_q[LAT];
  assign result_o = res_q;

  // checks
  logic clip_val;
  logic ratio_ok;

  assign clip_val = (result_o.gradient == GRAD_MAX) || (result_o.gradient == GRAD_MIN);
  assign ratio_ok = (r1quo_q[0][DIV1_STEPS] <= RATIO_ONE) &&
                    (r1quo_q[1][DIV1_STEPS] <= RATIO_ONE) &&
                    (r1quo_q[2][DIV1_STEPS] <= RATIO_ONE);

  `W5G_ASSERT(a_strobe_src, strobe_o, $past(start && !busy, LAT), "result without item")
  `W5G_ASSERT(a_sat_clip, strobe_o && result_o.saturated, clip_val, "saturated flag on unclipped value")
  `W5G_ASSERT(a_ratio_rng, vld_q[ST_R], ratio_ok, "ratio above one")
  `W5G_ASSERT_NEXT(a_cfg_wr, cfg_wr && cfg_sel, inv_q == $past(pwdata), "spacing write lost")

endmodule

FILE: test/tb_top.sv
// testbench of the weno5 upwind gradient core: random and directed items checked on the fly
`timescale 1ns / 100ps

module tb_top;
  import w5g_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         LATENCY     = 77;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         N_RANDOM    = 1150;

  // expected gradients and the predictor that forms them
  class gradient_board;
    w5g_out_t    grad_q[$];
    logic [31:0] inv_spacing = INV_RESET;
    int          errors = 0;
    int          checked = 0;
    int          clipped = 0;

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic longint unsigned absu(longint x);
      return x < 0 ? 64'd0 - longint'(x) : longint'(x);
    endfunction

    // difference times reciprocal spacing, clipped
    function automatic longint scale_diff(longint d);
      longint unsigned mag = absu(d);
      if (inv_spacing != 0 && mag > Q_LIM / inv_spacing) mag = Q_LIM;
      else mag = mag * inv_spacing;
      return d < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    // twelve times (eps + smoothness indicator)
    function automatic longint unsigned smooth(longint b, longint e);
      longint unsigned ub = absu(b), ue = absu(e), t1, t2, h;
      bit [127:0] g;
      t1 = 13 * ub;
      t2 = 3 * ue;
      g = {64'd0, t1} * {64'd0, ub} + {64'd0, t2} * {64'd0, ue};
      if ((g >> (64 + INT_FRAC)) != 0) h = '1;
      else h = 64'(g >> INT_FRAC);
      return (h > ~64'd0 - EPS12) ? ~64'd0 : h + EPS12;
    endfunction

    function automatic longint unsigned ratio(longint unsigned m, longint unsigned d);
      int s = 0;
      while (s < 32 && (d >> s) > 64'hFFFF_FFFF) s++;
      m = m >> s;
      d = d >> s;
      if (d == 0) return 64'd1 << 31;
      return (m << 31) / d;
    endfunction

    function automatic longint cand(longint n);
      longint unsigned mag = (absu(n) + 3) / 6;
      return n < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic w5g_out_t weno_gradient(w5g_in_t it);
      w5g_out_t r;
      longint s[7], q[5], p[3];
      longint unsigned d[3], a[3], w[3], m, rr, sum;
      bit signed [127:0] acc, t, sh;
      s[0] = it.sample_m3;     s[1] = it.sample_m2; s[2] = it.sample_m1;
      s[3] = it.sample_center; s[4] = it.sample_p1; s[5] = it.sample_p2;
      s[6] = it.sample_p3;
      r = '0;
      if (it.mode != MODE_POS && it.mode != MODE_NEG) return r;
      // mirrored stencil for negative flow
      for (int k = 0; k < 5; k++)
        q[k] = (it.mode == MODE_POS) ? scale_diff(s[k+1] - s[k]) : scale_diff(s[6-k] - s[5-k]);
      d[0] = smooth(q[0] - 2*q[1] + q[2], q[0] - 4*q[1] + 3*q[2]);
      d[1] = smooth(q[1] - 2*q[2] + q[3], q[1] - q[3]);
      d[2] = smooth(q[2] - 2*q[3] + q[4], 3*q[2] - 4*q[3] + q[4]);
      m = d[0];
      if (d[1] < m) m = d[1];
      if (d[2] < m) m = d[2];
      // nonlinear weights, normalized
      sum = 0;
      for (int k = 0; k < 3; k++) begin
        rr = ratio(m, d[k]);
        a[k] = ((k == 0) ? 1 : (k == 1) ? 6 : 3) * ((rr * rr) >> 31);
        sum += a[k];
      end
      for (int k = 0; k < 3; k++) w[k] = (a[k] << W_FRAC) / sum;
      p[0] = cand(2*q[0] - 7*q[1] + 11*q[2]);
      p[1] = cand(-q[1] + 5*q[2] + 2*q[3]);
      p[2] = cand(2*q[2] + 5*q[3] - q[4]);
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        t = $signed({64'd0, w[k]} * {64'd0, absu(p[k])});
        if (p[k] < 0) acc = acc - t;
        else acc = acc + t;
      end
      acc = acc + (128'sd1 <<< (OUT_SHIFT - 1));
      sh = acc >>> OUT_SHIFT;
      if (sh > 128'sd2147483647) begin
        r.gradient = GRAD_MAX; r.saturated = 1'b1;
      end else if (sh < -128'sd2147483648) begin
        r.gradient = GRAD_MIN; r.saturated = 1'b1;
      end else begin
        r.gradient = sh[31:0];
      end
      return r;
    endfunction

    function void note_item(w5g_in_t it);
      grad_q.push_back(weno_gradient(it));
    endfunction

    task check_result(w5g_out_t got);
      w5g_out_t want;
      if (grad_q.size() == 0) begin
        report("unexpected result", got.gradient, 32'd0);
        return;
      end
      want = grad_q.pop_front();
      checked++;
      if (got.saturated) clipped++;
      if (got.gradient !== want.gradient) report("gradient", got.gradient, want.gradient);
      if (got.saturated !== want.saturated) report("saturated", got.saturated, want.saturated);
    endtask
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  w5g_in_t             item_i = '0;
  logic                strobe_o;
  w5g_out_t            result_o;
  logic                psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  gradient_board board = new();
  int                  cycles = 0;
  int                  sent = 0;
  bit                  no_idle = 0;

  weno5_upwind_gradient_core uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // monitor and timeout
  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && start && !busy) board.note_item(item_i);
    if (rst_ni && strobe_o) board.check_result(result_o);
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // register write with readback
  task write_spacing(logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_INV_SPACING * 4); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.inv_spacing = val;
    @(negedge clk_i);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    if (rd !== val) board.report("inv_spacing readback", rd, val);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task wait_drained();
    while (board.grad_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // one item, with a random gap ahead of it unless no_idle is set
  task send_item(w5g_in_t it);
    int  gap;
    bit  was_busy;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do begin
      was_busy = busy;
      @(negedge clk_i);
    end while (was_busy);
    sent++;
  endtask

  function automatic logic [31:0] rand_sample(int kind, int idx, logic [31:0] base,
                                              logic [31:0] slope);
    case (kind)
      0: return $urandom();
      1: return base + idx * slope + $urandom_range(0, 255);
      2: return (idx > 3) ? base + 32'h0010_0000 : base;
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return base + (idx * idx) * slope;
    endcase
  endfunction

  function automatic w5g_in_t rand_item();
    w5g_in_t     it;
    int          kind = $urandom_range(0, 9);
    logic [31:0] base = $urandom(), slope, v[7];
    slope = $signed($urandom()) >>> $urandom_range(4, 24);
    if (kind > 4) kind = 1;
    for (int k = 0; k < 7; k++) v[k] = rand_sample(kind, k, base, slope);
    it.sample_m3 = v[0]; it.sample_m2 = v[1]; it.sample_m1 = v[2];
    it.sample_center = v[3]; it.sample_p1 = v[4]; it.sample_p2 = v[5];
    it.sample_p3 = v[6];
    case ($urandom_range(0, 9))
      0: it.mode = MODE_ZERO;
      1: it.mode = MODE_UNUSED;
      2, 3, 4, 5: it.mode = MODE_POS;
      default: it.mode = MODE_NEG;
    endcase
    return it;
  endfunction

  function automatic w5g_in_t fill_item(logic [31:0] v, logic [1:0] md);
    w5g_in_t it;
    it = {{7{v}}, md};
    return it;
  endfunction

  task run_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 97 == 0) no_idle = ($urandom_range(0, 2) == 0);
      send_item(rand_item());
    end
    start <= 1'b0;
    wait_drained();
  endtask

  logic [31:0] spacings[6];
  w5g_in_t     it;

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: modes, extremes, ramps, jumps
    write_spacing(INV_RESET);
    for (int md = 0; md < 4; md++) begin
      send_item(fill_item(32'h0000_0000, md[1:0]));
      send_item(fill_item(32'h7FFF_FFFF, md[1:0]));
    end
    it = '0;
    it.sample_m3 = 32'h8000_0000; it.sample_m2 = 32'h7FFF_FFFF; it.sample_m1 = 32'h8000_0000;
    it.sample_center = 32'h7FFF_FFFF; it.sample_p1 = 32'h8000_0000;
    it.sample_p2 = 32'h7FFF_FFFF; it.sample_p3 = 32'h8000_0000;
    it.mode = MODE_POS; send_item(it);
    it.mode = MODE_NEG; send_item(it);
    it.mode = MODE_UNUSED; send_item(it);
    for (int md = 1; md < 3; md++) begin
      it.sample_m3 = -32'sd196608; it.sample_m2 = -32'sd131072; it.sample_m1 = -32'sd65536;
      it.sample_center = 0; it.sample_p1 = 32'sd65536; it.sample_p2 = 32'sd131072;
      it.sample_p3 = 32'sd196608; it.mode = md[1:0];
      send_item(it);
      it.sample_p1 = 32'sd6553600; it.sample_p2 = 32'sd6553600; it.sample_p3 = 32'sd6553600;
      send_item(it);
      it.sample_m3 = 32'h8000_0000; it.sample_p3 = 32'h7FFF_FFFF;
      send_item(it);
    end
    start <= 1'b0;
    wait_drained();

    // random phases across spacing settings, the extremes among them
    spacings[0] = 32'd1;
    spacings[1] = 32'hFFFF_FFFF;
    spacings[2] = 32'd0;
    spacings[3] = $urandom_range(32'd4096, 32'd1048576);
    spacings[4] = $urandom();
    spacings[5] = INV_RESET;
    for (int ph = 0; ph < 6; ph++) begin
      write_spacing(spacings[ph]);
      send_item(fill_item(32'h7FFF_FFFF, MODE_POS));
      send_item(rand_item());
      run_random(N_RANDOM / 6);
    end

    repeat (LATENCY + 20) @(negedge clk_i);
    $display("%0d items sent over %0d spacing settings, all four modes", sent, 7);
    $display("%0d results checked, %0d of them saturated", board.checked, board.clipped);
    if (board.errors == 0 && board.grad_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d errors, %0d results missing", board.errors, board.grad_q.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: weno5_upwind_gradient_core.f
+incdir+design
design/w5g_pkg.sv
design/weno5_upwind_gradient_core.sv
test/tb_top.sv
